// ===== src/itwp_pkg.sv =====
// itwp_pkg: tag codes, request codes and the queue entry type for the tag word packer.
// No dependencies; used by every module of the block.
package itwp_pkg;

    localparam int unsigned SLOT_W  = 9;
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = 1;
    localparam int unsigned Q_CNT_W = 2;

    localparam logic [SLOT_W-1:0] SLOT_MAX    = 9'd511;
    localparam logic [SLOT_W-1:0] SLOTS_RESET = 9'd64;

    localparam logic [15:0] TAG_START = 16'h0100;
    localparam logic [15:0] TAG_DATA  = 16'h0200;
    localparam logic [15:0] TAG_STOP  = 16'h0300;
    localparam logic [15:0] TAG_REC   = 16'h0400;
    localparam logic [15:0] TAG_PAD   = 16'h0001;

    localparam logic [1:0] REQ_BEGIN = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_BYTE  = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // one accepted request: one or two result words
    typedef struct packed {
        logic        two;
        logic        v0;
        logic [31:0] w0;
        logic [31:0] w1;
        logic        fd;
    } t_entry;

endpackage

// ===== src/itwp_front.sv =====
// itwp_front: accepts requests, builds tags, holds the pending half and slot count.
// Depends on itwp_pkg; pushes one entry per request into itwp_queue.
module itwp_front
    import itwp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SLOT_W-1:0] i_cfg_wdata,
    input  logic              i_accept,
    input  logic [1:0]        i_req_type,
    input  logic [6:0]        i_target_address,
    input  logic [7:0]        i_data_byte,
    input  logic [7:0]        i_read_count,
    input  logic              i_stop_here,
    input  logic              i_read_follows,
    output t_entry            o_entry
);

    logic [SLOT_W-1:0] r_slots, n_slots;
    logic              r_hp, n_hp;
    logic [15:0]       r_held, n_held;
    logic [SLOT_W-1:0] r_cnt, n_cnt;

    logic [15:0]       t0, t1;
    logic              has_t0, has_t1, close_w;
    logic [SLOT_W:0]   sum2, sum;
    logic [1:0]        ntags;
    logic              clr;

    always_comb begin
        t0      = '0;
        t1      = '0;
        has_t0  = 1'b1;
        has_t1  = 1'b0;
        close_w = 1'b0;
        clr     = 1'b0;
        sum2    = {1'b0, r_cnt} + (SLOT_W+1)'(2);
        unique case (i_req_type)
            REQ_BEGIN: begin
                has_t0 = 1'b0;
                clr    = 1'b1;
            end
            REQ_START: begin
                t0 = TAG_START | {8'h00, i_target_address, 1'b0};
            end
            REQ_BYTE: begin
                if (i_stop_here) begin
                    t0      = TAG_STOP | {8'h00, i_data_byte};
                    close_w = 1'b1;
                end else if (i_read_follows && !r_hp && sum2 == {1'b0, r_slots}) begin
                    // near-full pad keeps the read's START and RECEIVE in one fill
                    t0     = TAG_DATA | {8'h00, i_data_byte};
                    t1     = TAG_PAD;
                    has_t1 = 1'b1;
                end else begin
                    t0 = TAG_DATA | {8'h00, i_data_byte};
                end
            end
            REQ_READ: begin
                t0      = TAG_START | {8'h00, i_target_address, 1'b1};
                t1      = TAG_REC | {8'h00, i_read_count};
                has_t1  = 1'b1;
                close_w = 1'b1;
            end
            default: begin
                has_t0 = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_entry = '0;
        n_hp    = r_hp;
        n_held  = r_held;
        if (clr) begin
            n_hp   = 1'b0;
            n_held = '0;
        end else if (has_t0) begin
            if (r_hp) begin
                o_entry.v0 = 1'b1;
                o_entry.w0 = {t0, r_held};
                n_hp       = 1'b0;
                n_held     = '0;
                if (has_t1) begin
                    if (close_w) begin
                        o_entry.two = 1'b1;
                        o_entry.w1  = {16'h0000, t1};
                    end else begin
                        n_hp   = 1'b1;
                        n_held = t1;
                    end
                end
            end else if (has_t1) begin
                o_entry.v0 = 1'b1;
                o_entry.w0 = {t1, t0};
            end else if (close_w) begin
                o_entry.v0 = 1'b1;
                o_entry.w0 = {16'h0000, t0};
            end else begin
                n_hp   = 1'b1;
                n_held = t0;
            end
        end

        ntags = {1'b0, has_t0} + {1'b0, has_t1};
        sum   = {1'b0, r_cnt} + {{(SLOT_W-1){1'b0}}, ntags};
        if (clr) begin
            n_cnt = '0;
        end else if (sum > {1'b0, SLOT_MAX}) begin
            n_cnt = SLOT_MAX;
        end else begin
            n_cnt = sum[SLOT_W-1:0];
        end
        o_entry.fd = (n_cnt >= r_slots);
        n_slots    = i_cfg_we ? i_cfg_wdata : r_slots;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= SLOTS_RESET;
            r_hp    <= 1'b0;
            r_held  <= '0;
            r_cnt   <= '0;
        end else begin
            r_slots <= n_slots;
            if (i_accept) begin
                r_hp   <= n_hp;
                r_held <= n_held;
                r_cnt  <= n_cnt;
            end
        end
    end

endmodule

// ===== src/itwp_queue.sv =====
// itwp_queue: short entry queue between front and back.
// Depends on itwp_pkg for t_entry and the depth constants.
module itwp_queue
    import itwp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_head,
    output logic   o_full,
    output logic   o_empty
);

    t_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, r_rp;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_head  = r_mem[r_rp];
    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== src/itwp_back.sv =====
// itwp_back: walks the head entry's one or two words out on the result channel.
// Depends on itwp_pkg; reads the head of itwp_queue.
module itwp_back
    import itwp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_entry      i_head,
    input  logic        i_empty,
    input  logic        i_stall,
    output logic        o_pop,
    output logic        o_valid,
    output logic        o_word_valid,
    output logic [31:0] o_fifo_word,
    output logic        o_run_last,
    output logic        o_fill_done
);

    logic r_second;
    logic last;
    logic take;

    assign o_valid      = !i_empty;
    assign last         = r_second || !i_head.two;
    assign take         = o_valid && !i_stall;
    assign o_pop        = take && last;
    assign o_word_valid = r_second ? 1'b1 : i_head.v0;
    assign o_fifo_word  = r_second ? i_head.w1 : i_head.w0;
    assign o_run_last   = last;
    assign o_fill_done  = i_head.fd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else if (take) begin
            r_second <= !last;
        end
    end

endmodule

// ===== src/i2c_tag_word_packer.sv =====
// i2c_tag_word_packer: top level, front tag builder, entry queue and result back end.
// Depends on itwp_pkg, itwp_front, itwp_queue and itwp_back.
//
// Request channel: i_valid / o_stall with one field per port. A word is taken
// at an edge where i_valid is high and o_stall low. o_stall rises only while
// the two-entry queue is full.
// Result channel: o_valid / i_stall. Each request gives one result, or two for
// a read that completes two words; o_run_last marks the final one. A result
// with o_word_valid low carries no FIFO word.
// A request's entry is registered into the queue; its first result is presented
// once it reaches the head. Requests are taken one per cycle while o_stall is low;
// a two-word read holds the result side until both its words are taken.
// When the receiver stalls, the head result holds and the queue fills; then
// o_stall rises. The user must write fifo_slots (reset 64) with i_cfg_we only
// while the block is idle; the block does not enforce this. Reset (i_rst_n
// low, synchronous) empties the queue and clears the held half and the slot count.
module i2c_tag_word_packer
    import itwp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SLOT_W-1:0] i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_req_type,
    input  logic [6:0]        i_target_address,
    input  logic [7:0]        i_data_byte,
    input  logic [7:0]        i_read_count,
    input  logic              i_stop_here,
    input  logic              i_read_follows,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_word_valid,
    output logic [31:0]       o_fifo_word,
    output logic              o_run_last,
    output logic              o_fill_done
);

    t_entry entry, head;
    logic   q_full, q_empty, pop, accept;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    itwp_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_accept         (accept),
        .i_req_type       (i_req_type),
        .i_target_address (i_target_address),
        .i_data_byte      (i_data_byte),
        .i_read_count     (i_read_count),
        .i_stop_here      (i_stop_here),
        .i_read_follows   (i_read_follows),
        .o_entry          (entry)
    );

    itwp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    itwp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_empty      (q_empty),
        .i_stall      (i_stall),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_word_valid (o_word_valid),
        .o_fifo_word  (o_fifo_word),
        .o_run_last   (o_run_last),
        .o_fill_done  (o_fill_done)
    );

endmodule
